// File: rtl/core/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types, widths and register codes of the random channel multiplexer.
// ----------------------------------------------------------------------------
package rcm_pkg;

   // Outputs handled by the block; output 0 is the idle output.
   localparam int unsigned MaxOutputs = 16;
   localparam int unsigned CountW     = $clog2(MaxOutputs + 1);
   localparam int unsigned IdxW       = $clog2(MaxOutputs);

   localparam int unsigned TimeW     = 16;
   localparam int unsigned RandByteW = 8;
   localparam int unsigned EnW       = 2;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 16;
   localparam int unsigned OcRegW    = 5;

   localparam int unsigned ReqDataW  = 64;
   localparam int unsigned RspDataW  = 16;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CsrMinTime  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrMaxTime  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrSlowMode = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrSeqMode  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrOutCount = 3'd4;

   // Enable state codes.
   localparam logic [EnW-1:0] EnOff     = 2'd0;
   localparam logic [EnW-1:0] EnOn      = 2'd1;
   localparam logic [EnW-1:0] EnFellOff = 2'd2;
   localparam logic [EnW-1:0] EnRoseOn  = 2'd3;

   typedef logic [MaxOutputs-1:0] sel_type;
   typedef logic [TimeW-1:0]      time_type;

endpackage

// File: rtl/core/random_channel_multiplexer_top.sv
// ----------------------------------------------------------------------------
// random_channel_multiplexer_top
// Keeps one of up to 16 outputs active and switches it after random intervals.
// ----------------------------------------------------------------------------
// Each request transfer is one evaluation tick: it carries the enable state,
// an init flag, the fast and slow time counters and fresh random numbers.
// While enabled, the block waits min_time plus a random share of the span
// (max_time - min_time) mod 2^16, then activates another output, picked at
// random or in sequence; when disabled it falls back to idle output 0. Every
// request gives exactly one response with the one-hot selection and an
// "updated" flag. Throughput is one transfer per clock; the response appears
// the cycle after acceptance. The whole evaluation (16x16 interval multiply,
// 8x5 pick multiply, elapsed time compare, lowest-active-output search) is
// combinational between the request port and the response register. The
// response register is freed in the same cycle it is taken, so back-to-back
// transfers never stall unless the response side holds off.
// ----------------------------------------------------------------------------
module random_channel_multiplexer_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] enable_state, [17:2] time_fast, [33:18] time_slow,
   // [49:34] rand_word, [57:50] rand_byte, [63:58] zero
   input  logic [rcm_pkg::ReqDataW-1:0]   req_tdata,
   // [0] init
   input  logic                           req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] selected_onehot
   output logic [rcm_pkg::RspDataW-1:0]   rsp_tdata,
   // [0] updated
   output logic                           rsp_tuser,
   // configuration write port
   input  logic                           csr_we,
   input  logic [rcm_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [rcm_pkg::CsrDataW-1:0]   csr_wdata
);

   // configuration registers
   rcm_pkg::time_type              min_time_ff;
   rcm_pkg::time_type              max_time_ff;
   logic                           slow_mode_ff;
   logic                           seq_mode_ff;
   logic [rcm_pkg::OcRegW-1:0]     out_count_ff;

   // evaluation state
   rcm_pkg::time_type              start_time_ff, start_time_in;
   rcm_pkg::time_type              interval_ff, interval_in;
   rcm_pkg::sel_type               selection_ff, selection_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   rcm_pkg::sel_type               rsp_sel_ff;
   logic                           rsp_upd_ff, rsp_upd_in;

   // request fields
   logic [rcm_pkg::EnW-1:0]        en_raw;
   logic [rcm_pkg::EnW-1:0]        en;
   rcm_pkg::time_type              time_fast;
   rcm_pkg::time_type              time_slow;
   rcm_pkg::time_type              rand_word;
   logic [rcm_pkg::RandByteW-1:0]  rand_byte;
   rcm_pkg::time_type              now;

   // datapath
   logic                           accept;
   logic [rcm_pkg::CountW-1:0]     count;
   logic [rcm_pkg::CountW-1:0]     count_m1;
   rcm_pkg::time_type              span;
   logic [2*rcm_pkg::TimeW-1:0]    scaled;
   rcm_pkg::time_type              new_interval;
   rcm_pkg::time_type              elapsed;
   logic                           expired;
   logic [rcm_pkg::RandByteW+rcm_pkg::CountW-1:0] pick_prod;
   logic [rcm_pkg::CountW-1:0]     act_rand;
   logic [rcm_pkg::IdxW-1:0]       low_idx;
   logic                           low_found;
   logic [rcm_pkg::CountW-1:0]     act_seq;
   logic [rcm_pkg::CountW-1:0]     act;
   rcm_pkg::sel_type               picked;
   logic                           do_pick;
   logic                           do_idle;

   // --- handshake: response slot frees in the cycle it is taken ---
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   assign en_raw    = req_tdata[1:0];
   assign time_fast = req_tdata[17:2];
   assign time_slow = req_tdata[33:18];
   assign rand_word = req_tdata[49:34];
   assign rand_byte = req_tdata[57:50];
   assign now       = slow_mode_ff ? time_slow : time_fast;

   // init forces a clean edge: bit 0 set means just turned on
   always_comb begin
      if (req_tuser) begin
         en = en_raw[0] ? rcm_pkg::EnRoseOn : rcm_pkg::EnFellOff;
      end else begin
         en = en_raw;
      end
   end

   // effective output count: 0 acts as 1, clamped to the block size
   always_comb begin
      if (out_count_ff == '0) begin
         count = rcm_pkg::CountW'(1);
      end else if (rcm_pkg::CountW'(out_count_ff) > rcm_pkg::CountW'(rcm_pkg::MaxOutputs)) begin
         count = rcm_pkg::CountW'(rcm_pkg::MaxOutputs);
      end else begin
         count = rcm_pkg::CountW'(out_count_ff);
      end
   end
   assign count_m1 = count - rcm_pkg::CountW'(1);

   // --- interval: min + (rand_word * span) >> 16, all mod 2^16 ---
   assign span         = max_time_ff - min_time_ff;
   assign scaled       = rand_word * span;
   assign new_interval = min_time_ff + scaled[2*rcm_pkg::TimeW-1:rcm_pkg::TimeW];

   assign elapsed = now - start_time_ff;
   assign expired = (elapsed >= interval_ff);

   // --- random pick: 1 + (rand_byte * (count-1)) >> 8 ---
   assign pick_prod = rand_byte * count_m1;
   assign act_rand  = pick_prod[rcm_pkg::RandByteW+rcm_pkg::CountW-1:rcm_pkg::RandByteW]
                      + rcm_pkg::CountW'(1);

   // --- sequential pick: lowest active output below count, plus one ---
   always_comb begin
      low_idx   = '0;
      low_found = 1'b0;
      for (int i = rcm_pkg::MaxOutputs - 1; i >= 0; i--) begin
         if (selection_ff[i] && (rcm_pkg::CountW'(i) < count)) begin
            low_idx   = rcm_pkg::IdxW'(i);
            low_found = 1'b1;
         end
      end
   end

   always_comb begin
      act_seq = rcm_pkg::CountW'(low_idx) + rcm_pkg::CountW'(1);
      if (!low_found || (act_seq > count_m1)) begin
         act_seq = rcm_pkg::CountW'(1);
      end
   end

   assign act = seq_mode_ff ? act_seq : act_rand;

   // pick out of range (single-output case) leaves nothing active
   always_comb begin
      picked = '0;
      if (act < count) begin
         picked = rcm_pkg::sel_type'(1) << act[rcm_pkg::IdxW-1:0];
      end
   end

   assign do_pick = (en == rcm_pkg::EnRoseOn) || ((en == rcm_pkg::EnOn) && expired);
   assign do_idle = (en == rcm_pkg::EnFellOff);

   // --- next state ---
   always_comb begin
      start_time_in = start_time_ff;
      interval_in   = interval_ff;
      selection_in  = selection_ff;
      rsp_upd_in    = 1'b0;
      if (do_pick) begin
         start_time_in = now;
         interval_in   = new_interval;
         selection_in  = picked;
         rsp_upd_in    = 1'b1;
      end else if (do_idle) begin
         selection_in  = rcm_pkg::sel_type'(1);
         rsp_upd_in    = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // --- control and state registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         min_time_ff   <= '0;
         max_time_ff   <= '0;
         slow_mode_ff  <= 1'b0;
         seq_mode_ff   <= 1'b0;
         out_count_ff  <= rcm_pkg::OcRegW'(2);
         start_time_ff <= '0;
         interval_ff   <= '0;
         selection_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            start_time_ff <= start_time_in;
            interval_ff   <= interval_in;
            selection_ff  <= selection_in;
         end
         if (csr_we) begin
            case (csr_index)
               rcm_pkg::CsrMinTime:  min_time_ff  <= csr_wdata;
               rcm_pkg::CsrMaxTime:  max_time_ff  <= csr_wdata;
               rcm_pkg::CsrSlowMode: slow_mode_ff <= csr_wdata[0];
               rcm_pkg::CsrSeqMode:  seq_mode_ff  <= csr_wdata[0];
               rcm_pkg::CsrOutCount: out_count_ff <= csr_wdata[rcm_pkg::OcRegW-1:0];
               default: ;
            endcase
         end
      end
   end

   // --- response payload ---
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sel_ff <= selection_in;
         rsp_upd_ff <= rsp_upd_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rcm_pkg::RspDataW'(rsp_sel_ff);
   assign rsp_tuser  = rsp_upd_ff;

endmodule

// File: dv/rcm_checker.sv
// ----------------------------------------------------------------------------
// rcm_checker
// Watches the multiplexer's channels, predicts every response and compares.
// ----------------------------------------------------------------------------
module rcm_checker
   import rcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int unsigned         mismatches,
   output int unsigned         pending,
   output int unsigned         rewrites
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sel_type onehot;
      logic    updated;
   } tick_result_t;

   // shadow registers
   time_type           cfg_lo;
   time_type           cfg_hi;
   logic               cfg_slow;
   logic               cfg_seq;
   logic [OcRegW-1:0]  cfg_count;

   // shadow state
   time_type           mark_time;
   time_type           wait_len;
   sel_type            active_sel;

   tick_result_t       selection_q[$];

   function automatic int unsigned live_outputs();
      int unsigned n;
      n = cfg_count;
      if (n == 0) n = 1;
      if (n > MaxOutputs) n = MaxOutputs;
      return n;
   endfunction

   function automatic sel_type bit_for(input int unsigned act, input int unsigned n);
      return (act >= n) ? '0 : sel_type'(1) << act;
   endfunction

   function automatic void restart_timer(input time_type now, input logic [15:0] rw);
      time_type    span;
      logic [31:0] scaled;
      span      = cfg_hi - cfg_lo;
      scaled    = (32'(rw) * 32'(span)) >> 16;
      mark_time = now;
      wait_len  = cfg_lo + scaled[15:0];
   endfunction

   function automatic void choose_output(input logic [RandByteW-1:0] rb);
      int unsigned n;
      int unsigned act;
      n = live_outputs();
      if (cfg_seq) begin
         // step past the lowest active output; nothing active restarts at 1
         act = 255;
         for (int unsigned i = 0; i < n; i++) begin
            if (active_sel[i]) begin
               act = i + 1;
               break;
            end
         end
         if (act > n - 1) act = 1;
      end else begin
         act = 1 + ((32'(rb) * (n - 1)) >> 8);
      end
      active_sel = bit_for(act, n);
   endfunction

   function automatic tick_result_t evaluate_tick(input logic [ReqDataW-1:0] d,
                                                  input logic init);
      logic [EnW-1:0]       en;
      time_type             now;
      time_type             elapsed;
      logic [15:0]          rw;
      logic [RandByteW-1:0] rb;
      tick_result_t         r;
      en  = d[1:0];
      now = cfg_slow ? d[33:18] : d[17:2];
      rw  = d[49:34];
      rb  = d[57:50];
      r.updated = 1'b0;
      // with init set, only bit 0 of the enable matters
      if (init) en = en[0] ? EnRoseOn : EnFellOff;
      elapsed = now - mark_time;
      if (en == EnRoseOn || (en == EnOn && elapsed >= wait_len)) begin
         restart_timer(now, rw);
         choose_output(rb);
         r.updated = 1'b1;
      end else if (en == EnFellOff) begin
         active_sel = bit_for(0, live_outputs());
         r.updated  = 1'b1;
      end
      r.onehot = active_sel;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns rcm mismatch: %s got 0x%0h want 0x%0h",
               $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      tick_result_t want;
      if (reset) begin
         cfg_lo     = '0;
         cfg_hi     = '0;
         cfg_slow   = 1'b0;
         cfg_seq    = 1'b0;
         cfg_count  = OcRegW'(2);
         mark_time  = '0;
         wait_len   = '0;
         active_sel = '0;
         selection_q.delete();
         mismatches = 0;
         rewrites   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrMinTime:  cfg_lo    = csr_wdata;
               CsrMaxTime:  cfg_hi    = csr_wdata;
               CsrSlowMode: cfg_slow  = csr_wdata[0];
               CsrSeqMode:  cfg_seq   = csr_wdata[0];
               CsrOutCount: cfg_count = csr_wdata[OcRegW-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            selection_q.push_back(evaluate_tick(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser) rewrites++;
            if (selection_q.size() == 0) begin
               flag_mismatch("response with nothing pending", 32'(rsp_tdata), 32'd0);
            end else begin
               want = selection_q.pop_front();
               if (rsp_tdata !== want.onehot)
                  flag_mismatch("selected_onehot", 32'(rsp_tdata), 32'(want.onehot));
               if (rsp_tuser !== want.updated)
                  flag_mismatch("updated", 32'(rsp_tuser), 32'(want.updated));
            end
         end
      end
      pending = selection_q.size();
   end

endmodule

// File: dv/tb_random_channel_multiplexer_top.sv
// ----------------------------------------------------------------------------
// tb_random_channel_multiplexer_top
// Stimulus and verdict for the random channel multiplexer.
// ----------------------------------------------------------------------------
// A short directed part walks every enable code, the init remapping, timer
// wrap, sequential stepping with wrap-around and the field extremes. Then ten
// register settings (zero and full intervals, wrapping span, counts of 0, 1,
// 2, 16 and above 16, both time bases, both pick modes) each get a run of
// ticks: mostly coherent time sequences with sparse enable edges, the rest
// pure noise. rcm_checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_random_channel_multiplexer_top import rcm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CalmPhase   = 6;   // no idling on either side
   localparam int HoldPhase   = 8;   // receiver holds off at the start
   localparam int HoldCycles  = 300;
   localparam int TicksPerSet = 193;

   typedef struct packed {
      time_type          lo;
      time_type          hi;
      logic              slow;
      logic              seq;
      logic [OcRegW-1:0] count;
      logic [15:0]       step_max;   // largest time advance per coherent tick
   } setting_t;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int unsigned         mismatches;
   int unsigned         pending;
   int unsigned         rewrites;
   int unsigned         ticks_sent;
   int unsigned         settings_used;
   int                  phase_no;

   always #6 clock = ~clock;

   random_channel_multiplexer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rcm_checker rcm_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .rewrites   (rewrites)
   );

   // One tick transfer. Random idle cycles go in front of it; valid then
   // stays up until the handshake completes.
   task automatic offer_tick(input logic init, input logic [EnW-1:0] en,
                             input time_type tf, input time_type ts,
                             input logic [15:0] rw, input logic [RandByteW-1:0] rb);
      @(negedge clock);
      while (phase_no != CalmPhase && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= init;
      req_tdata  <= {6'b0, rb, rw, ts, tf, en};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Sender pauses until every response is back, then a few spare cycles.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Single-bit and count registers get junk in their unused upper bits.
   task automatic program_regs(input setting_t s);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CsrMinTime;
      csr_wdata <= s.lo;
      @(negedge clock);
      csr_index <= CsrMaxTime;
      csr_wdata <= s.hi;
      @(negedge clock);
      csr_index <= CsrSlowMode;
      csr_wdata <= {15'($urandom), s.slow};
      @(negedge clock);
      csr_index <= CsrSeqMode;
      csr_wdata <= {15'($urandom), s.seq};
      @(negedge clock);
      csr_index <= CsrOutCount;
      csr_wdata <= {11'($urandom), s.count};
      @(negedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // Mostly a running clock with the enable held on and rare edges; about
   // one tick in seven is fully random noise.
   task automatic run_setting(input setting_t s);
      time_type    tf;
      time_type    ts;
      logic        on;
      logic        init;
      int unsigned roll;
      tf = 16'($urandom);
      ts = 16'($urandom);
      on = 1'b1;
      program_regs(s);
      for (int k = 0; k < TicksPerSet; k++) begin
         if ($urandom_range(0, 99) < 15) begin
            offer_tick(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom));
         end else begin
            tf   = tf + 16'($urandom_range(0, s.step_max));
            ts   = ts + 16'($urandom_range(0, s.step_max));
            roll = $urandom_range(0, 99);
            init = (roll < 2);
            if ((on && roll < 4) || (!on && roll < 30)) begin
               on = !on;
               offer_tick(init, on ? EnRoseOn : EnFellOff, tf, ts,
                          16'($urandom), 8'($urandom));
            end else begin
               offer_tick(init, on ? EnOn : EnOff, tf, ts,
                          16'($urandom), 8'($urandom));
            end
         end
      end
      drain();
   endtask

   // Response side: random back-pressure, none in the calm phase, and one
   // long hold-off so the block backs up into the request port.
   initial begin : rsp_side
      int unsigned hold_left;
      logic        hold_used;
      hold_left  = 0;
      hold_used  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_no == HoldPhase && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (phase_no == CalmPhase) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 28);
         end
      end
   end

   initial begin : stimulus
      setting_t plan [10];
      setting_t fixed;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CsrMinTime;
      csr_wdata     = '0;
      ticks_sent    = 0;
      settings_used = 0;
      phase_no      = 0;

      //          lo        hi        slow  seq   count   step
      plan[0] = '{16'd0,    16'd0,    1'b0, 1'b0, 5'd16,  16'd50};
      plan[1] = '{16'd100,  16'd600,  1'b0, 1'b1, 5'd5,   16'd300};
      plan[2] = '{16'd2000, 16'd500,  1'b1, 1'b0, 5'd31,  16'd4000};   // span wraps
      plan[3] = '{16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 5'd0,   16'hFFFF};   // count 0
      plan[4] = '{16'd0,    16'hFFFF, 1'b1, 1'b0, 5'd1,   16'd20000};  // single output
      plan[5] = '{16'd10,   16'd40,   1'b0, 1'b1, 5'd16,  16'd30};
      plan[6] = '{16'd5,    16'd6,    1'b1, 1'b1, 5'd2,   16'd10};
      plan[7] = '{16'd300,  16'd1000, 1'b0, 1'b0, 5'd17,  16'd800};
      plan[8] = '{16'd0,    16'd1,    1'b0, 1'b1, 5'd3,   16'd3};
      plan[9] = '{16'd1234, 16'd4321, 1'b1, 1'b0, 5'd9,   16'd3000};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: enable codes, init remap, timer wrap, pick extremes
      fixed = '{16'd10, 16'd20, 1'b0, 1'b0, 5'd16, 16'd0};
      program_regs(fixed);
      offer_tick(1'b1, EnOff,     16'h0000, 16'hFFFF, 16'h0000, 8'h00);
      offer_tick(1'b1, EnOn,      16'h0000, 16'h0000, 16'hFFFF, 8'hFF);
      offer_tick(1'b0, EnOn,      16'h0005, 16'hFFFF, 16'h0000, 8'h00);
      offer_tick(1'b0, EnOn,      16'h0013, 16'h0000, 16'h0000, 8'h80);
      offer_tick(1'b0, EnOff,     16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      offer_tick(1'b0, EnFellOff, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      offer_tick(1'b1, EnFellOff, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA);
      offer_tick(1'b1, EnRoseOn,  16'hFFF0, 16'h0000, 16'h0000, 8'h00);
      offer_tick(1'b0, EnRoseOn,  16'hFFFF, 16'h1234, 16'h8000, 8'h01);
      offer_tick(1'b0, EnOn,      16'h000D, 16'hFFFF, 16'hFFFF, 8'hFE);
      offer_tick(1'b0, EnOn,      16'h000E, 16'h0000, 16'hAAAA, 8'h55);
      offer_tick(1'b0, EnOn,      16'h000E, 16'hFFFF, 16'h5555, 8'h7F);
      drain();

      // directed: sequential stepping, wrap past count-1, restart from idle
      fixed = '{16'd0, 16'd0, 1'b1, 1'b1, 5'd4, 16'd0};
      program_regs(fixed);
      offer_tick(1'b0, EnRoseOn,  16'hFFFF, 16'h0000, 16'h1111, 8'h11);
      offer_tick(1'b0, EnOn,      16'h0000, 16'h0005, 16'h2222, 8'h22);
      offer_tick(1'b0, EnOn,      16'h0001, 16'h0009, 16'h3333, 8'h33);
      offer_tick(1'b0, EnOn,      16'h0002, 16'hFFFF, 16'h4444, 8'h44);
      offer_tick(1'b0, EnFellOff, 16'h0003, 16'h0000, 16'h0000, 8'h00);
      offer_tick(1'b0, EnOn,      16'h0004, 16'h0001, 16'hFFFF, 8'hFF);
      offer_tick(1'b1, EnOff,     16'h0005, 16'h0002, 16'h0000, 8'h00);
      offer_tick(1'b1, EnOn,      16'h0006, 16'h0003, 16'h0000, 8'h00);
      drain();

      for (int p = 0; p < 10; p++) begin
         phase_no = p + 1;
         run_setting(plan[p]);
      end
      phase_no = 0;

      repeat (8) @(negedge clock);
      $display("rcm run: %0d tick transfers under %0d register settings, %0d rewrites seen",
               ticks_sent, settings_used, rewrites);
      $display("rcm run: enable codes, init remap, timer wrap, both pick modes, odd counts");
      if (mismatches == 0 && pending == 0) begin
         $display("[random_channel_multiplexer_top] OK");
      end else begin
         $display("[random_channel_multiplexer_top] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_400_000;
      $display("[random_channel_multiplexer_top] ERROR");
      $finish;
   end

endmodule
